FILE: sv/led_pkg.sv
// Package for the line editor: sequencer states, operation codes and constants.
package led_pkg;

  localparam int LINE_DEPTH_DEF    = 64;
  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int LIMIT_W           = 7;

  localparam logic [7:0] CODE_EOF   = 8'd4;
  localparam logic [7:0] CODE_LF    = 8'd10;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] CODE_DEL   = 8'd127;

  localparam logic [7:0] CFG_KEYS_EDIT    = 8'd0;
  localparam logic [7:0] CFG_KEYS_MOTION  = 8'd1;
  localparam logic [7:0] CFG_KEYS_HISTORY = 8'd2;
  localparam logic [7:0] CFG_LINE_LIMIT   = 8'd3;

  localparam logic [31:0] KEYS_EDIT_RST    = 32'h090B0408;
  localparam logic [31:0] KEYS_MOTION_RST  = 32'h05010602;
  localparam logic [23:0] KEYS_HISTORY_RST = 24'h0A0E10;
  localparam logic [LIMIT_W-1:0] LINE_LIMIT_RST = 7'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN      = 7'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SHL_RD, S_SHL_WR, S_SHR_RD, S_SHR_WR, S_INS_PUT,
    S_REC_RD, S_REC_WR, S_NL_RD, S_NL_OUT, S_NL_TERM, S_CLAMP
  } state_t;

  typedef enum logic [3:0] {
    OP_EOF, OP_ERASE, OP_DELETE, OP_LEFT, OP_RIGHT, OP_HOME, OP_END,
    OP_OLDER, OP_NEWER, OP_KILL, OP_TOGGLE, OP_NEWLINE, OP_PRINT, OP_NONE
  } op_t;

endpackage

FILE: sv/led_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module led_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/line_editor_with_history.sv
// Top level of the line editor: key decode, edit sequencer, line and history stores.
// Erase, delete, recall, insert and a line end walk the stored characters one at a time,
// and each walk step waits on the registered RAM read. Busy is high while a key is in
// work, so no new key is taken until the last one is through; results cannot be stalled,
// and synchronous reset clears the sequencer, the key map, the limit, the line and the
// history counters and the result strobe, but not the RAM contents.
module line_editor_with_history #(
  parameter int LINE_DEPTH    = led_pkg::LINE_DEPTH_DEF,
  parameter int HISTORY_DEPTH = led_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  key_code,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [7:0]  out_char,
  output logic        last_of_line,
  output logic        end_of_input
);
  import led_pkg::*;

  localparam int LA = $clog2(LINE_DEPTH);
  localparam int LW = $clog2(LINE_DEPTH + 1);
  localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int HN = HISTORY_DEPTH * LINE_DEPTH;
  localparam int HA = $clog2(HN);

  state_t state, state_next;
  op_t    op;

  logic [31:0]        keys_edit, keys_motion;
  logic [23:0]        keys_history_line;
  logic [LIMIT_W-1:0] line_limit;

  logic [7:0]    key;
  logic [LW-1:0] len, cur, idx, endp, pos;
  logic          ovw;
  logic [CW-1:0] ridp1, hcnt;
  logic [SW-1:0] head, rslot, new_slot, rec_slot;
  logic [LW-1:0] hlen [HISTORY_DEPTH];
  logic [CW-1:0] rec_k;
  logic [SW:0]   slot_sum;
  logic          rec_ok;
  logic [LW-1:0] rec_n;

  logic [LIMIT_W-1:0] eff, cap7;
  logic [LW-1:0]      cap;

  logic          lwe, hwe;
  logic [LA-1:0] lwa, lra;
  logic [7:0]    lwd, lrd, hrd;
  logic [HA-1:0] hwa, hra;

  assign busy = (state != S_IDLE);

  // Key decode in the fixed priority order.
  always_comb begin
    if (key == CODE_EOF && len == '0) op = OP_EOF;
    else if (key == keys_edit[7:0])           op = OP_ERASE;
    else if (key == keys_edit[15:8])          op = OP_DELETE;
    else if (key == keys_motion[7:0])         op = OP_LEFT;
    else if (key == keys_motion[15:8])        op = OP_RIGHT;
    else if (key == keys_motion[23:16])       op = OP_HOME;
    else if (key == keys_motion[31:24])       op = OP_END;
    else if (key == keys_history_line[7:0])   op = OP_OLDER;
    else if (key == keys_history_line[15:8])  op = OP_NEWER;
    else if (key == keys_edit[23:16])         op = OP_KILL;
    else if (key == keys_edit[31:24])         op = OP_TOGGLE;
    else if (key == keys_history_line[23:16] || key == CODE_CR || key == CODE_LF)
      op = OP_NEWLINE;
    else if (key >= PRINT_LOW && key < CODE_DEL) op = OP_PRINT;
    else op = OP_NONE;
  end

  // History slot arithmetic: newest line sits at head, older ones behind it.
  always_comb begin
    new_slot = (head == SW'(HISTORY_DEPTH - 1)) ? '0 : SW'(head + 1'b1);
    rec_k    = (op == OP_OLDER) ? ridp1 : CW'(ridp1 - 2'd2);
    slot_sum = (SW + 1)'(head) + (SW + 1)'(HISTORY_DEPTH) - (SW + 1)'(rec_k);
    if (slot_sum >= (SW + 1)'(HISTORY_DEPTH)) begin
      slot_sum = slot_sum - (SW + 1)'(HISTORY_DEPTH);
    end
    rec_slot = slot_sum[SW-1:0];
    rec_n    = hlen[rec_slot];
    rec_ok   = (op == OP_OLDER) ? (ridp1 < hcnt) : (ridp1 > CW'(1));
  end

  // Content cap from the limit register.
  always_comb begin
    eff = line_limit;
    if (eff < LIMIT_MIN) eff = LIMIT_MIN;
    if (eff > LIMIT_W'(LINE_DEPTH)) eff = LIMIT_W'(LINE_DEPTH);
    cap7 = eff - LIMIT_W'(2);
    cap  = cap7[LW-1:0];
  end

  // Next state and memory controls.
  always_comb begin
    state_next = state;
    lwe = 1'b0;
    lwa = idx[LA-1:0];
    lwd = lrd;
    lra = idx[LA-1:0];
    hwe = 1'b0;
    hwa = HA'(new_slot) * HA'(LINE_DEPTH) + HA'(idx[LA-1:0]);
    hra = HA'(rslot) * HA'(LINE_DEPTH) + HA'(idx[LA-1:0]);
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (op) inside
          OP_EOF:    state_next = S_IDLE;
          OP_ERASE:  state_next = (cur != '0 && cur < len) ? S_SHL_RD : S_CLAMP;
          OP_DELETE: state_next = (LW'(cur + 1'b1) < len) ? S_SHL_RD : S_CLAMP;
          OP_OLDER, OP_NEWER:
            state_next = (rec_ok && rec_n != '0) ? S_REC_RD : S_CLAMP;
          OP_NEWLINE: state_next = (len == '0) ? S_NL_TERM : S_NL_RD;
          OP_PRINT: begin
            if (ovw) begin
              lwe = (cur < LW'(LINE_DEPTH));
              lwa = cur[LA-1:0];
              lwd = key;
              state_next = S_CLAMP;
            end else if (len < LW'(LINE_DEPTH)) begin
              state_next = (len == cur) ? S_INS_PUT : S_SHR_RD;
            end else begin
              state_next = S_CLAMP;
            end
          end
          default: state_next = S_CLAMP;
        endcase
      end
      S_SHL_RD: state_next = S_SHL_WR;
      S_SHL_WR: begin
        lwe = 1'b1;
        lwa = LA'(idx - 1'b1);
        state_next = (LW'(idx + 1'b1) == endp) ? S_CLAMP : S_SHL_RD;
      end
      S_SHR_RD: begin
        lra = LA'(idx - 1'b1);
        state_next = S_SHR_WR;
      end
      S_SHR_WR: begin
        lwe = 1'b1;
        state_next = (LW'(idx - 1'b1) == pos) ? S_INS_PUT : S_SHR_RD;
      end
      S_INS_PUT: begin
        lwe = 1'b1;
        lwa = pos[LA-1:0];
        lwd = key;
        state_next = S_CLAMP;
      end
      S_REC_RD: state_next = S_REC_WR;
      S_REC_WR: begin
        lwe = 1'b1;
        lwd = hrd;
        state_next = (LW'(idx + 1'b1) == endp) ? S_CLAMP : S_REC_RD;
      end
      S_NL_RD: state_next = S_NL_OUT;
      S_NL_OUT: begin
        hwe = 1'b1;
        state_next = (LW'(idx + 1'b1) == len) ? S_NL_TERM : S_NL_RD;
      end
      S_NL_TERM: state_next = S_IDLE;
      S_CLAMP:   state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Sequencer state and editing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      keys_edit         <= KEYS_EDIT_RST;
      keys_motion       <= KEYS_MOTION_RST;
      keys_history_line <= KEYS_HISTORY_RST;
      line_limit        <= LINE_LIMIT_RST;
      len               <= '0;
      cur               <= '0;
      ovw               <= 1'b0;
      ridp1             <= '0;
      hcnt              <= '0;
      head              <= '0;
      result_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;

      // Configuration writes.
      if (cfg_write) begin
        case (cfg_index)
          CFG_KEYS_EDIT:    keys_edit         <= cfg_data;
          CFG_KEYS_MOTION:  keys_motion       <= cfg_data;
          CFG_KEYS_HISTORY: keys_history_line <= cfg_data[23:0];
          CFG_LINE_LIMIT:   line_limit        <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) key <= key_code;
        end
        S_DECODE: begin
          case (op) inside
            OP_EOF: begin
              result_valid <= 1'b1;
              out_char     <= CODE_EOF;
              last_of_line <= 1'b0;
              end_of_input <= 1'b1;
            end
            OP_ERASE: begin
              if (cur != '0) begin
                idx  <= cur;
                endp <= len;
                len  <= LW'(len - 1'b1);
                cur  <= LW'(cur - 1'b1);
              end
            end
            OP_DELETE: begin
              if (cur < len) begin
                idx  <= LW'(cur + 1'b1);
                endp <= len;
                len  <= LW'(len - 1'b1);
              end
            end
            OP_LEFT:   if (cur != '0) cur <= LW'(cur - 1'b1);
            OP_RIGHT:  if (cur < len) cur <= LW'(cur + 1'b1);
            OP_HOME:   cur <= '0;
            OP_END:    cur <= len;
            OP_OLDER, OP_NEWER: begin
              if (rec_ok) begin
                ridp1 <= (op == OP_OLDER) ? CW'(ridp1 + 1'b1) : CW'(ridp1 - 1'b1);
                rslot <= rec_slot;
                endp  <= rec_n;
                len   <= rec_n;
                cur   <= rec_n;
                idx   <= '0;
              end
            end
            OP_KILL:    len <= cur;
            OP_TOGGLE:  ovw <= ~ovw;
            OP_NEWLINE: idx <= '0;
            OP_PRINT: begin
              if (ovw) begin
                if (cur < LW'(LINE_DEPTH)) begin
                  cur <= LW'(cur + 1'b1);
                  if (len < LW'(cur + 1'b1)) len <= LW'(cur + 1'b1);
                end
              end else if (len < LW'(LINE_DEPTH)) begin
                idx <= len;
                pos <= cur;
                cur <= LW'(cur + 1'b1);
                len <= LW'(len + 1'b1);
              end
            end
            default: ;
          endcase
        end
        S_SHL_WR: idx <= LW'(idx + 1'b1);
        S_SHR_WR: idx <= LW'(idx - 1'b1);
        S_REC_WR: idx <= LW'(idx + 1'b1);
        S_NL_OUT: begin
          result_valid <= 1'b1;
          out_char     <= lrd;
          last_of_line <= 1'b0;
          end_of_input <= 1'b0;
          idx          <= LW'(idx + 1'b1);
        end
        S_NL_TERM: begin
          result_valid   <= 1'b1;
          out_char       <= key;
          last_of_line   <= 1'b1;
          end_of_input   <= 1'b0;
          hlen[new_slot] <= len;
          head           <= new_slot;
          if (hcnt < CW'(HISTORY_DEPTH)) hcnt <= CW'(hcnt + 1'b1);
          len   <= '0;
          cur   <= '0;
          ridp1 <= '0;
        end
        S_CLAMP: begin
          if (len >= cap) begin
            len <= cap;
            if (cur > cap) cur <= cap;
          end
        end
        default: ;
      endcase
    end
  end

  // Edit line store.
  led_ram #(.DEPTH(LINE_DEPTH), .WIDTH(8)) u_line_ram (
    .clk   (clk),
    .we    (lwe),
    .waddr (lwa),
    .wdata (lwd),
    .raddr (lra),
    .rdata (lrd)
  );

  // History store, one row of LINE_DEPTH characters per slot.
  led_ram #(.DEPTH(HN), .WIDTH(8)) u_hist_ram (
    .clk   (clk),
    .we    (hwe),
    .waddr (hwa),
    .wdata (lrd),
    .raddr (hra),
    .rdata (hrd)
  );

endmodule

FILE: bench/line_editor_with_history_tb.sv
// Self-checking testbench for the line editor with history, with a scoreboard class.
`timescale 1ns / 100ps

module line_editor_with_history_tb;
  import led_pkg::*;

  localparam logic [7:0] CFG_UNUSED = 8'd200;

  // Expected line characters, with the editor state kept alongside to predict them.
  class line_scoreboard;
    typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       eoi;
    } echo_t;

    echo_t      echo_q[$];
    int         errors;
    logic [31:0] edit_keys, motion_keys;
    logic [23:0] hist_keys;
    logic [6:0]  limit;
    logic [7:0]  line_buf[64];
    int          len, cur, recall, hcount;
    bit          ovw;
    logic [7:0]  hist_buf[16][64];
    int          hist_len[16];

    function new();
      errors = 0;
      edit_keys = KEYS_EDIT_RST;
      motion_keys = KEYS_MOTION_RST;
      hist_keys = KEYS_HISTORY_RST;
      limit = LINE_LIMIT_RST;
      len = 0;
      cur = 0;
      recall = -1;
      hcount = 0;
      ovw = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      case (idx)
        CFG_KEYS_EDIT: edit_keys = data;
        CFG_KEYS_MOTION: motion_keys = data;
        CFG_KEYS_HISTORY: hist_keys = data[23:0];
        CFG_LINE_LIMIT: limit = data[6:0];
        default: ;
      endcase
    endfunction

    function void recall_line(int k);
      int n;
      n = hist_len[k] > 62 ? 62 : hist_len[k];
      for (int i = 0; i < n; i++) line_buf[i] = hist_buf[k][i];
      len = n;
      cur = n;
    endfunction

    // Apply one accepted key transaction to the predicted state.
    function void note_key(logic [7:0] c);
      int cap;
      if (c == CODE_EOF && len == 0) begin
        echo_q.push_back('{CODE_EOF, 1'b0, 1'b1});
        return;
      end
      if (c == edit_keys[7:0]) begin
        if (cur > 0) begin
          for (int i = cur; i < len; i++) line_buf[i-1] = line_buf[i];
          len--;
          cur--;
        end
      end else if (c == edit_keys[15:8]) begin
        if (cur < len) begin
          for (int i = cur; i + 1 < len; i++) line_buf[i] = line_buf[i+1];
          len--;
        end
      end else if (c == motion_keys[7:0]) begin
        if (cur > 0) cur--;
      end else if (c == motion_keys[15:8]) begin
        if (cur < len) cur++;
      end else if (c == motion_keys[23:16]) begin
        cur = 0;
      end else if (c == motion_keys[31:24]) begin
        cur = len;
      end else if (c == hist_keys[7:0]) begin
        if (recall + 1 < hcount) begin
          recall++;
          recall_line(recall);
        end
      end else if (c == hist_keys[15:8]) begin
        if (recall > 0) begin
          recall--;
          recall_line(recall);
        end
      end else if (c == edit_keys[23:16]) begin
        len = cur;
      end else if (c == edit_keys[31:24]) begin
        ovw = !ovw;
      end else if (c == hist_keys[23:16] || c == CODE_CR || c == CODE_LF) begin
        for (int i = 0; i < len; i++) echo_q.push_back('{line_buf[i], 1'b0, 1'b0});
        echo_q.push_back('{c, 1'b1, 1'b0});
        for (int k = 15; k > 0; k--) begin
          hist_buf[k] = hist_buf[k-1];
          hist_len[k] = hist_len[k-1];
        end
        hist_buf[0] = line_buf;
        hist_len[0] = len;
        if (hcount < 16) hcount++;
        len = 0;
        cur = 0;
        recall = -1;
        return;
      end else if (c >= PRINT_LOW && c < CODE_DEL) begin
        if (ovw) begin
          line_buf[cur] = c;
          cur++;
          if (len < cur) len = cur;
        end else begin
          for (int i = len; i > cur; i--) line_buf[i] = line_buf[i-1];
          line_buf[cur] = c;
          cur++;
          len++;
        end
      end
      // Content is kept to the effective limit minus two.
      cap = limit < 4 ? 4 : (limit > 64 ? 64 : limit);
      cap = cap - 2;
      if (len >= cap) begin
        len = cap;
        if (cur > len) cur = len;
      end
    endfunction

    function void check(logic [7:0] ch, logic last, logic eoi);
      echo_t e;
      if (echo_q.size() == 0) begin
        $error("unexpected result: out_char %0d", ch);
        errors++;
        return;
      end
      e = echo_q.pop_front();
      if (ch !== e.ch) begin
        $error("out_char: expected %0d, actual %0d", e.ch, ch);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_line: expected %0d, actual %0d", e.last, last);
        errors++;
      end
      if (eoi !== e.eoi) begin
        $error("end_of_input: expected %0d, actual %0d", e.eoi, eoi);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [7:0]  key_code = 0;
  logic        cfg_write = 0;
  logic [7:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic        result_valid;
  logic [7:0]  out_char;
  logic        last_of_line;
  logic        end_of_input;

  line_scoreboard sb = new();
  int idle_pct;

  line_editor_with_history dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .key_code(key_code),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .out_char(out_char),
    .last_of_line(last_of_line), .end_of_input(end_of_input)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && result_valid) sb.check(out_char, last_of_line, end_of_input);
  end

  // Offer one key and hold it until the editor takes it; called at a rising edge.
  task automatic send_key(logic [7:0] k);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    key_code <= k;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sb.note_key(k);
  endtask

  // Stop sending and wait until every expected result has come and the editor is idle.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (sb.echo_q.size() != 0 || busy);
    repeat (160) @(posedge clk);
  endtask

  // One register write, with cfg_write dropped again before anything else is driven.
  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly text with edit commands from the current key map, some line ends and noise.
  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(32, 126));
    if (r < 65) return sb.edit_keys[8*$urandom_range(3) +: 8];
    if (r < 78) return sb.motion_keys[8*$urandom_range(3) +: 8];
    if (r < 85) return sb.hist_keys[8*$urandom_range(1) +: 8];
    if (r < 92) begin
      case ($urandom_range(2))
        0: return CODE_CR;
        1: return CODE_LF;
        default: return sb.hist_keys[23:16];
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  initial begin
    logic [7:0] directed[$];
    int idle_sched[6];
    directed = '{CODE_EOF, 8'd8, "a", "b", "c", 8'd2, 8'd2, 8'd6, 8'd1, 8'd5,
                 8'd16, 8'd14, "Z", 8'd2, 8'd11, 8'd9, "X", 8'd9, 8'd2, 8'd4,
                 8'd0, 8'd255, CODE_DEL, 8'd32, 8'd126, CODE_CR, "q", CODE_LF,
                 8'd16, 8'd16, 8'd14, 8'd10};
    idle_sched = '{0, 62, 0, 12, 62, 0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed keys on the reset key map.
    idle_pct = 0;
    foreach (directed[i]) send_key(directed[i]);
    drain();

    for (int p = 0; p < 6; p++) begin
      idle_pct = idle_sched[p];
      case (p)
        1: begin
          write_reg(CFG_LINE_LIMIT, 32'd0);
          write_reg(CFG_UNUSED, 32'hFFFFFFFF);
        end
        2: begin
          write_reg(CFG_KEYS_EDIT, 32'hFFFFFFFF);
          write_reg(CFG_KEYS_MOTION, 32'h00000000);
          write_reg(CFG_KEYS_HISTORY, 32'hFFFFFFFF);
          write_reg(CFG_LINE_LIMIT, 32'hFFFFFF7F);
        end
        3: begin
          // Printable codes used as commands: the command meaning wins.
          write_reg(CFG_KEYS_EDIT, 32'h2D7E613F);
          write_reg(CFG_KEYS_MOTION, 32'h3C3E5B5D);
          write_reg(CFG_KEYS_HISTORY, 32'h215E76);
          write_reg(CFG_LINE_LIMIT, 32'd9);
        end
        4: begin
          write_reg(CFG_KEYS_EDIT, KEYS_EDIT_RST);
          write_reg(CFG_KEYS_MOTION, KEYS_MOTION_RST);
          write_reg(CFG_KEYS_HISTORY, KEYS_HISTORY_RST);
          write_reg(CFG_LINE_LIMIT, 32'd64);
        end
        5: write_reg(CFG_LINE_LIMIT, 32'd4);
        default: ;
      endcase
      for (int n = 0; n < 80; n++) begin
        send_key(pick_key());
        // Once, midway through the second pass, hold off until everything owed has come back.
        if (n == 40 && p == 1) drain();
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
